>>> src/fifo_message_deframer_console_ring_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the message deframer console ring
// Both macros sample on the rising clock edge and hold off during reset.
// ----------------------------------------------------------------------------
`ifndef FIFO_MESSAGE_DEFRAMER_CONSOLE_RING_MACROS_SVH
`define FIFO_MESSAGE_DEFRAMER_CONSOLE_RING_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FMDCR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FMDCR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/fmdcr_pkg.sv
// ----------------------------------------------------------------------------
// fmdcr_pkg
// Sizes, widths and codes shared by the message deframer console ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fmdcr_pkg;

   // Ring size must be a power of two: pointers wrap by truncation.
   localparam int RING_BYTES = 1024;
   localparam int PKT_BYTES  = 2048;
   localparam int PKT_WORDS  = (PKT_BYTES + 7) / 8;

   localparam int RING_AW  = $clog2(RING_BYTES);
   localparam int LEN_W    = $clog2(PKT_BYTES);
   localparam int PKT_AW   = $clog2(PKT_WORDS);
   localparam int BR_W     = LEN_W + 1;
   localparam int FREE_W   = RING_AW + 1;
   localparam int CMP_W    = (FREE_W > LEN_W) ? FREE_W : LEN_W;
   localparam int HDR_W    = 17;

   localparam int WORD_W   = 64;
   localparam int BYTE_W   = 8;
   localparam int EV_W     = 4;
   localparam int USED_W   = 10;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic CMD_RX   = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [7:0] TYPE_NET     = 8'd1;
   localparam logic [7:0] TYPE_CONSOLE = 8'd3;

   localparam logic [CSR_AW-3:0] REG_NET_UP = '0;

   localparam logic [EV_W-1:0] EV_PAYLOAD    = 4'd0;
   localparam logic [EV_W-1:0] EV_HEADER     = 4'd1;
   localparam logic [EV_W-1:0] EV_ZERO_SKIP  = 4'd2;
   localparam logic [EV_W-1:0] EV_TOO_LONG   = 4'd3;
   localparam logic [EV_W-1:0] EV_CON_STORED = 4'd4;
   localparam logic [EV_W-1:0] EV_CON_NOSPC  = 4'd5;
   localparam logic [EV_W-1:0] EV_NET_DONE   = 4'd6;
   localparam logic [EV_W-1:0] EV_DROPPED    = 4'd7;
   localparam logic [EV_W-1:0] EV_READ_EMPTY = 4'd8;

endpackage

`default_nettype wire

>>> src/fmdcr_ram.sv
// ----------------------------------------------------------------------------
// fmdcr_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fmdcr_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

>>> src/fifo_message_deframer_console_ring.sv
// ----------------------------------------------------------------------------
// fifo_message_deframer_console_ring
// Splits length-prefixed receive words into messages, copies console
// messages into a byte ring and serves one-byte console reads.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_command, req_rx_word
//   rsp      out  rsp_valid/rsp_stall   read_byte, byte_valid, event_res,
//                                       console_used, data_pending
//   csr      in   psel/penable/pwrite   paddr, pwdata, prdata (net_up)
//
// A receive word without copy passes ST_IDLE and ST_EMIT; a console read
// adds ST_RD_WAIT for the registered ring RAM read. A completed console
// message adds a copy: one packet RAM read per word (ST_CP_RD), then one
// ring byte write per cycle (ST_CP_WR) through the single ring write port.
// Reset is synchronous and clears control state only; the two RAMs are
// not cleared and need no clearing pass.
// A result waits in the output register under rsp_stall while the next
// transaction is taken; the block holds before emitting if it is still full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fifo_message_deframer_console_ring
   import fmdcr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic              req_command,
   input  wire logic [WORD_W-1:0] req_rx_word,

   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic [BYTE_W-1:0] rsp_read_byte,
   output      logic              rsp_byte_valid,
   output      logic [EV_W-1:0]   rsp_event_res,
   output      logic [USED_W-1:0] rsp_console_used,
   output      logic              rsp_data_pending,

   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output      logic [CSR_DW-1:0] prdata,
   output      logic              pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_CP_RD,
      ST_CP_WR,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [RING_AW-1:0] head_ff, head_in;
   logic [RING_AW-1:0] tail_ff, tail_in;
   logic [RING_AW-1:0] wp_ff, wp_in;
   logic [7:0]         type_ff, type_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [BR_W-1:0]    br_ff, br_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic [EV_W-1:0]    ev_ff, ev_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               bvalid_ff, bvalid_in;
   logic               net_up_ff, net_up_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_bvalid_ff, rsp_bvalid_in;
   logic [EV_W-1:0]    rsp_ev_ff, rsp_ev_in;
   logic [USED_W-1:0]  rsp_used_ff, rsp_used_in;
   logic               rsp_pend_ff, rsp_pend_in;

   logic               ring_we, ring_re;
   logic [RING_AW-1:0] ring_waddr, ring_raddr;
   logic [BYTE_W-1:0]  ring_wdata, ring_rdata;
   logic               pkt_we, pkt_re;
   logic [PKT_AW-1:0]  pkt_waddr, pkt_raddr;
   logic [WORD_W-1:0]  pkt_wdata, pkt_rdata;

   logic               accept;
   logic [15:0]        hdr_len;
   logic [BR_W-1:0]    br_next;
   logic               msg_done;
   logic [RING_AW-1:0] used;
   logic [FREE_W-1:0]  free_bytes;
   logic               fits;
   logic [LEN_W-1:0]   idx_inc;
   logic               emit;
   logic               csr_write;

   fmdcr_ram #(.DEPTH(RING_BYTES), .WIDTH(BYTE_W)) u_ring (
      .clock (clock),
      .we    (ring_we),
      .waddr (ring_waddr),
      .wdata (ring_wdata),
      .re    (ring_re),
      .raddr (ring_raddr),
      .rdata (ring_rdata)
   );

   fmdcr_ram #(.DEPTH(PKT_WORDS), .WIDTH(WORD_W)) u_pkt (
      .clock (clock),
      .we    (pkt_we),
      .waddr (pkt_waddr),
      .wdata (pkt_wdata),
      .re    (pkt_re),
      .raddr (pkt_raddr),
      .rdata (pkt_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   // Length is big-endian: high byte in bits 55:48, low byte in 63:56.
   assign hdr_len    = {req_rx_word[55:48], req_rx_word[63:56]};
   assign br_next    = br_ff + BR_W'(8);
   assign msg_done   = (br_next >= {1'b0, len_ff});
   assign used       = tail_ff - head_ff;
   assign free_bytes = FREE_W'(RING_BYTES) - {1'b0, used};
   assign fits       = (CMP_W'(free_bytes) > CMP_W'(len_ff));
   assign idx_inc    = idx_ff + LEN_W'(1);
   assign emit       = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   assign csr_write  = psel && penable && pwrite && pready;

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      wp_in     = wp_ff;
      type_in   = type_ff;
      len_in    = len_ff;
      br_in     = br_ff;
      idx_in    = idx_ff;
      ev_in     = ev_ff;
      byte_in   = byte_ff;
      bvalid_in = bvalid_ff;

      ring_we    = 1'b0;
      ring_waddr = wp_ff;
      ring_wdata = 8'(pkt_rdata >> {idx_ff[2:0], 3'b000});
      ring_re    = 1'b0;
      ring_raddr = head_ff;
      pkt_we     = 1'b0;
      pkt_waddr  = br_ff[LEN_W-1:3];
      pkt_wdata  = req_rx_word;
      pkt_re     = 1'b0;
      pkt_raddr  = idx_ff[LEN_W-1:3];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               byte_in   = '0;
               bvalid_in = 1'b0;
               state_in  = ST_EMIT;
               if (req_command == CMD_READ) begin
                  if (head_ff == tail_ff) begin
                     ev_in = EV_READ_EMPTY;
                  end else begin
                     ring_re  = 1'b1;
                     state_in = ST_RD_WAIT;
                  end
               end else if (len_ff == '0) begin
                  if (hdr_len == '0) begin
                     ev_in = EV_ZERO_SKIP;
                  end else if ({1'b0, hdr_len} >= HDR_W'(PKT_BYTES)) begin
                     ev_in = EV_TOO_LONG;
                     br_in = '0;
                  end else begin
                     ev_in   = EV_HEADER;
                     type_in = req_rx_word[7:0];
                     len_in  = LEN_W'(hdr_len);
                     br_in   = '0;
                  end
               end else begin
                  pkt_we = 1'b1;
                  br_in  = br_next;
                  ev_in  = EV_PAYLOAD;
                  if (msg_done) begin
                     br_in  = '0;
                     len_in = '0;
                     if (type_ff == TYPE_CONSOLE) begin
                        if (fits) begin
                           // keep the length until the copy ends
                           ev_in    = EV_CON_STORED;
                           len_in   = len_ff;
                           idx_in   = '0;
                           wp_in    = tail_ff;
                           state_in = ST_CP_RD;
                        end else begin
                           ev_in = EV_CON_NOSPC;
                        end
                     end else if (type_ff == TYPE_NET) begin
                        ev_in = net_up_ff ? EV_NET_DONE : EV_DROPPED;
                     end else begin
                        ev_in = EV_DROPPED;
                     end
                  end
               end
            end
         end
         ST_RD_WAIT: begin
            byte_in   = ring_rdata;
            bvalid_in = 1'b1;
            ev_in     = EV_PAYLOAD;
            head_in   = head_ff + RING_AW'(1);
            state_in  = ST_EMIT;
         end
         ST_CP_RD: begin
            pkt_re   = 1'b1;
            state_in = ST_CP_WR;
         end
         ST_CP_WR: begin
            ring_we = 1'b1;
            wp_in   = wp_ff + RING_AW'(1);
            idx_in  = idx_inc;
            if (idx_inc == len_ff) begin
               tail_in  = wp_ff + RING_AW'(1);
               len_in   = '0;
               state_in = ST_EMIT;
            end else if (idx_ff[2:0] == 3'd7) begin
               state_in = ST_CP_RD;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = emit || (rsp_valid_ff && rsp_stall);
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_pend_in   = rsp_pend_ff;
      if (emit) begin
         rsp_byte_in   = byte_ff;
         rsp_bvalid_in = bvalid_ff;
         rsp_ev_in     = ev_ff;
         rsp_used_in   = USED_W'(used);
         rsp_pend_in   = (used != '0);
      end
   end

   always_comb begin
      net_up_in = net_up_ff;
      if (csr_write && (paddr[CSR_AW-1:2] == REG_NET_UP)) begin
         net_up_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         type_ff      <= '0;
         len_ff       <= '0;
         br_ff        <= '0;
         net_up_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         type_ff      <= type_in;
         len_ff       <= len_in;
         br_ff        <= br_in;
         net_up_ff    <= net_up_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wp_ff         <= wp_in;
      idx_ff        <= idx_in;
      ev_ff         <= ev_in;
      byte_ff       <= byte_in;
      bvalid_ff     <= bvalid_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_pend_ff   <= rsp_pend_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_byte    = rsp_byte_ff;
   assign rsp_byte_valid   = rsp_bvalid_ff;
   assign rsp_event_res    = rsp_ev_ff;
   assign rsp_console_used = rsp_used_ff;
   assign rsp_data_pending = rsp_pend_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[CSR_AW-1:2] == REG_NET_UP) ? CSR_DW'(net_up_ff) : '0;

endmodule

`default_nettype wire

>>> src/fmdcr_checker.sv
// ----------------------------------------------------------------------------
// fmdcr_checker
// Port-level checks on the result channel of the message deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fifo_message_deframer_console_ring_macros.svh"

module fmdcr_checker
   import fmdcr_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [BYTE_W-1:0] rsp_read_byte,
   input wire logic              rsp_byte_valid,
   input wire logic [EV_W-1:0]   rsp_event_res,
   input wire logic [USED_W-1:0] rsp_console_used,
   input wire logic              rsp_data_pending
);

   // pending flag must track the fill level
   `FMDCR_ASSERT_SAME(a_pending_used, rsp_valid, rsp_data_pending == (rsp_console_used != '0), "data_pending disagrees with console_used")

   // a returned byte only comes with a successful read
   `FMDCR_ASSERT_SAME(a_byte_event, rsp_valid && rsp_byte_valid, rsp_event_res == EV_PAYLOAD, "byte_valid without a successful read")

   // no byte: the byte lane reads zero
   `FMDCR_ASSERT_SAME(a_byte_zero, rsp_valid && !rsp_byte_valid, rsp_read_byte == '0, "read_byte nonzero without byte_valid")

   // hold a stalled transaction
   `FMDCR_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_event_res) && $stable(rsp_console_used), "stalled result changed")

endmodule

bind fifo_message_deframer_console_ring fmdcr_checker u_fmdcr_checker (.*);

`default_nettype wire

>>> sim/tb_fifo_message_deframer_console_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_message_deframer_console_ring
// Drives receive words and console reads into the message deframer and
// checks every response against a cycle-free model of the deframer and the
// console byte ring. A short directed pass covers the header corner cases.
// Random phases follow: the ring is filled to the last free byte and then
// drained past its wrap point. The net_up register is toggled between
// phases, and the output side is held off once to back up the input.
// ----------------------------------------------------------------------------

module tb_fifo_message_deframer_console_ring;
   import fmdcr_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int MAX_WAIT     = 18;
   localparam int SETTLE       = 8;
   localparam int HOLD_AT      = 800;
   localparam int HOLD_CYCLES  = 400;
   localparam logic [CSR_AW-1:0] NET_UP_ADDR = {REG_NET_UP, 2'b00};

   typedef struct packed {
      logic              command;
      logic [WORD_W-1:0] word;
   } rx_request_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rd_byte;
      logic              rd_valid;
      logic [EV_W-1:0]   ev;
      logic [USED_W-1:0] used;
      logic              pending;
   } console_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_command = CMD_RX;
   logic [WORD_W-1:0] req_rx_word = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [BYTE_W-1:0] rsp_read_byte;
   logic              rsp_byte_valid;
   logic [EV_W-1:0]   rsp_event_res;
   logic [USED_W-1:0] rsp_console_used;
   logic              rsp_data_pending;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   fifo_message_deframer_console_ring dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_rx_word      (req_rx_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_event_res    (rsp_event_res),
      .rsp_console_used (rsp_console_used),
      .rsp_data_pending (rsp_data_pending),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // Deframer and ring model state
   logic [BYTE_W-1:0]  ring_model [RING_BYTES];
   logic [WORD_W-1:0]  staged_words [PKT_WORDS];
   logic [RING_AW-1:0] ring_rd = '0;
   logic [RING_AW-1:0] ring_wr = '0;
   logic [7:0]         frame_type = '0;
   int                 frame_len = 0;
   int                 frame_got = 0;
   logic               net_up_model = 1'b0;

   rx_request_type     request_backlog [$];
   console_result_type predicted_results [$];

   int  ev_seen [16];
   int  requests_made = 0;
   int  requests_taken = 0;
   int  results_seen = 0;
   int  mismatches = 0;
   int  peak_level = 0;
   int  read_wraps = 0;
   int  bytes_read = 0;
   bit  filling = 1'b1;
   bit  send_burst = 1'b0;
   bit  recv_burst = 1'b0;
   int  send_gap = 0;
   int  stall_left = 0;
   rx_request_type     next_request;
   console_result_type oldest_result;

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatches++;
      $display("%0t MISMATCH %s at response %0d: got 0x%0h, expected 0x%0h",
               $time, what, results_seen, got, want);
   endtask

   function automatic int draw_wait(input bit burst);
      return burst ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic int ring_level();
      logic [RING_AW-1:0] span;
      span = ring_wr - ring_rd;
      return int'(span);
   endfunction

   function automatic logic [WORD_W-1:0] header_word(input logic [7:0] typ,
                                                     input logic [15:0] len);
      logic [63:0] filler;
      filler = {$urandom, $urandom};
      return {len[7:0], len[15:8], filler[39:0], typ};
   endfunction

   // Advance the deframer and ring by one transaction; return its response.
   function automatic console_result_type deframe_and_ring_step(input logic cmd,
                                                                input logic [WORD_W-1:0] w);
      console_result_type r;
      int                 len;
      int                 level;
      int                 i;
      logic [RING_AW-1:0] slot;
      logic [WORD_W-1:0]  staged;
      r = '0;
      if (cmd == CMD_READ) begin
         if (ring_rd == ring_wr) begin
            r.ev = EV_READ_EMPTY;
         end else begin
            r.rd_byte  = ring_model[ring_rd];
            r.rd_valid = 1'b1;
            ring_rd    = ring_rd + 1'b1;
            if (ring_rd == 0) read_wraps++;
            bytes_read++;
            r.ev = EV_PAYLOAD;
         end
      end else if (frame_len == 0) begin
         len = int'({w[55:48], w[63:56]});
         if (len == 0) begin
            r.ev = EV_ZERO_SKIP;
         end else if (len >= PKT_BYTES) begin
            r.ev      = EV_TOO_LONG;
            frame_got = 0;
         end else begin
            frame_type = w[7:0];
            frame_len  = len;
            frame_got  = 0;
            r.ev       = EV_HEADER;
         end
      end else begin
         staged_words[(frame_got >> 3) % PKT_WORDS] = w;
         frame_got += 8;
         if (frame_got < frame_len) begin
            r.ev = EV_PAYLOAD;
         end else begin
            if (frame_type == TYPE_CONSOLE) begin
               // a message goes in whole, and only if it leaves a byte free
               if (RING_BYTES - ring_level() > frame_len) begin
                  for (i = 0; i < frame_len; i++) begin
                     slot   = ring_wr + i[RING_AW-1:0];
                     staged = staged_words[i >> 3];
                     ring_model[slot] = staged[(i % 8) * 8 +: 8];
                  end
                  ring_wr = ring_wr + frame_len[RING_AW-1:0];
                  r.ev    = EV_CON_STORED;
               end else begin
                  r.ev = EV_CON_NOSPC;
               end
            end else if (frame_type == TYPE_NET) begin
               r.ev = net_up_model ? EV_NET_DONE : EV_DROPPED;
            end else begin
               r.ev = EV_DROPPED;
            end
            frame_len = 0;
            frame_got = 0;
         end
      end
      level     = ring_level();
      r.used    = level[USED_W-1:0];
      r.pending = (level != 0);
      if (level > peak_level) peak_level = level;
      ev_seen[r.ev]++;
      return r;
   endfunction

   task automatic push_request(input logic cmd, input logic [WORD_W-1:0] w);
      rx_request_type item;
      item.command = cmd;
      item.word    = w;
      request_backlog.push_back(item);
      predicted_results.push_back(deframe_and_ring_step(cmd, w));
      requests_made++;
   endtask

   task automatic send_reads(input int count);
      repeat (count) push_request(CMD_READ, {$urandom, $urandom});
   endtask

   // Header plus payload; a cut-short message leaves the deframer mid-frame.
   task automatic send_message(input logic [7:0] typ, input int len, input bit cut_short);
      int words;
      int i;
      words = (len > 0 && len < PKT_BYTES) ? (len + 7) / 8 : 0;
      if (cut_short && words > 0) words = $urandom_range(0, words - 1);
      push_request(CMD_RX, header_word(typ, len[15:0]));
      for (i = 0; i < words; i++) begin
         if ($urandom_range(0, 19) == 0) send_reads(1);
         push_request(CMD_RX, {$urandom, $urandom});
      end
   endtask

   function automatic int draw_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 85) return filling ? $urandom_range(1, 64) : $urandom_range(1, 16);
      if (pick < 97) return filling ? $urandom_range(65, 400) : $urandom_range(17, 100);
      return $urandom_range(101, PKT_BYTES - 1);
   endfunction

   task automatic run_random_phase(input int target, input bit until_wrap);
      int         start;
      int         pick;
      int         level;
      logic [7:0] typ;
      start = requests_made;
      while ((requests_made - start < target || (until_wrap && read_wraps == 0))
             && requests_made - start < 4 * target) begin
         pick  = $urandom_range(0, 99);
         level = ring_level();
         if (pick < (filling ? 10 : 80)) begin
            send_reads($urandom_range(1, 24));
         end else if (pick < (filling ? 16 : 86)) begin
            case ($urandom_range(0, 2))
               0: send_message(8'($urandom_range(0, 255)), 0, 1'b0);
               1: send_message(8'($urandom_range(0, 255)), $urandom_range(PKT_BYTES, 65535),
                               1'b0);
               default: send_message(TYPE_CONSOLE, $urandom_range(9, 200), 1'b1);
            endcase
         end else begin
            pick = $urandom_range(0, 99);
            typ  = (pick < 70) ? TYPE_CONSOLE : (pick < 85) ? TYPE_NET
                                              : 8'($urandom_range(0, 255));
            if (filling && typ == TYPE_CONSOLE && level >= 700 && frame_len == 0) begin
               // exactly the free space is refused, one byte less fills the ring
               send_message(TYPE_CONSOLE, RING_BYTES - level, 1'b0);
               send_message(TYPE_CONSOLE, RING_BYTES - 1 - level, 1'b0);
               filling = 1'b0;
            end else begin
               send_message(typ, draw_length(), 1'b0);
            end
         end
         if (filling && ring_level() > 950) filling = 1'b0;
         if (!filling && ring_level() < 40) filling = 1'b1;
      end
   endtask

   task automatic set_net_up(input logic value);
      logic [CSR_DW-1:0] data;
      data    = $urandom;
      data[0] = value;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= NET_UP_ADDR;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      net_up_model = value;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[0] !== value) flag_mismatch("net_up readback", prdata[0], value);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (request_backlog.size() != 0 || predicted_results.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            requests_taken++;
            if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
            send_gap = draw_wait(send_burst);
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               next_request = request_backlog.pop_front();
               req_valid   <= 1'b1;
               req_command <= next_request.command;
               req_rx_word <= next_request.word;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and output stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (predicted_results.size() == 0) begin
               flag_mismatch("response with nothing outstanding", rsp_event_res, '0);
            end else begin
               oldest_result = predicted_results.pop_front();
               if (rsp_read_byte !== oldest_result.rd_byte)
                  flag_mismatch("read_byte", rsp_read_byte, oldest_result.rd_byte);
               if (rsp_byte_valid !== oldest_result.rd_valid)
                  flag_mismatch("byte_valid", rsp_byte_valid, oldest_result.rd_valid);
               if (rsp_event_res !== oldest_result.ev)
                  flag_mismatch("event_res", rsp_event_res, oldest_result.ev);
               if (rsp_console_used !== oldest_result.used)
                  flag_mismatch("console_used", rsp_console_used, oldest_result.used);
               if (rsp_data_pending !== oldest_result.pending)
                  flag_mismatch("data_pending", rsp_data_pending, oldest_result.pending);
            end
            if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
            // hold off once for long enough to back up the request side
            stall_left = (results_seen == HOLD_AT) ? HOLD_CYCLES : draw_wait(recv_burst);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #25ms;
      $display("%0t timeout: %0d responses outstanding, %0d requests unsent",
               $time, predicted_results.size(), request_backlog.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      set_net_up(1'b0);
      @(negedge clock);

      // Header corner cases and the first console bytes, interface down
      push_request(CMD_READ, '1);
      push_request(CMD_RX, header_word(TYPE_CONSOLE, 16'd0));
      push_request(CMD_RX, header_word(TYPE_CONSOLE, 16'(PKT_BYTES)));
      push_request(CMD_RX, header_word(TYPE_NET, 16'hFFFF));
      push_request(CMD_RX, header_word(TYPE_CONSOLE, 16'd1));
      push_request(CMD_RX, '1);
      push_request(CMD_READ, '0);
      push_request(CMD_READ, '1);
      push_request(CMD_RX, header_word(TYPE_CONSOLE, 16'd9));
      push_request(CMD_RX, '0);
      push_request(CMD_RX, {$urandom, $urandom});
      send_message(TYPE_CONSOLE, 8, 1'b0);
      send_reads(2);
      send_message(TYPE_NET, 5, 1'b0);
      send_message(8'hFF, 16, 1'b0);
      send_message(8'h00, 3, 1'b0);
      wait_drained();

      set_net_up(1'b1);
      @(negedge clock);
      send_message(TYPE_NET, 8, 1'b0);
      run_random_phase(400, 1'b0);
      wait_drained();

      set_net_up(1'b0);
      @(negedge clock);
      send_message(8'($urandom_range(0, 255)), PKT_BYTES - 1, 1'b0);
      run_random_phase(400, 1'b0);
      wait_drained();

      set_net_up(1'b1);
      @(negedge clock);
      run_random_phase(400, 1'b1);
      wait_drained();

      $display("Coverage: %0d transactions, %0d bytes read back, %0d empty reads",
               requests_taken, bytes_read, ev_seen[EV_READ_EMPTY]);
      $display("Coverage: %0d console stored, %0d refused for space, %0d net done",
               ev_seen[EV_CON_STORED], ev_seen[EV_CON_NOSPC], ev_seen[EV_NET_DONE]);
      $display("Coverage: %0d dropped, %0d skipped, %0d too long, peak fill %0d, wraps %0d",
               ev_seen[EV_DROPPED], ev_seen[EV_ZERO_SKIP], ev_seen[EV_TOO_LONG],
               peak_level, read_wraps);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
